// ----- src/aarm_pkg.sv -----
// Package: shared types, constants and arithmetic helpers for the rotation matrix unit.
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int AXIS_WIDTH   = FRAC_BITS + 2;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;
    localparam int CS_SHIFT     = 30 - FRAC_BITS;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int PIPE_STAGES  = CORDIC_STEPS + 5;
    localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);
    localparam logic signed [AXIS_WIDTH-1:0] ONE_Q = AXIS_WIDTH'(1 << FRAC_BITS);
    localparam int PW = 2 * AXIS_WIDTH + 2;

    typedef logic signed [AXIS_WIDTH-1:0] q_t;
    // 1 - c spans up to two, one bit more than an entry
    typedef logic signed [AXIS_WIDTH:0]   tq_t;

    typedef struct packed {
        q_t                     ax;
        q_t                     ay;
        q_t                     az;
        logic [ANGLE_WIDTH-1:0] angle;
    } req_t;

    typedef struct packed {
        q_t m00; q_t m01; q_t m02;
        q_t m10; q_t m11; q_t m12;
        q_t m20; q_t m21; q_t m22;
    } mat_t;

    function automatic logic signed [CW-1:0] atan_turn(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0: r = CW'(32'h20000000);  1: r = CW'(32'h12E4051D);
            2: r = CW'(32'h09FB385B);  3: r = CW'(32'h051111D4);
            4: r = CW'(32'h028B0D43);  5: r = CW'(32'h0145D7E1);
            6: r = CW'(32'h00A2F61E);  7: r = CW'(32'h00517C55);
            8: r = CW'(32'h0028BE53);  9: r = CW'(32'h00145F2F);
            10: r = CW'(32'h000A2F98); 11: r = CW'(32'h000517CC);
            12: r = CW'(32'h00028BE6); 13: r = CW'(32'h000145F3);
            14: r = CW'(32'h0000A2F9); 15: r = CW'(32'h0000517D);
            16: r = CW'(32'h000028BE); 17: r = CW'(32'h0000145F);
            18: r = CW'(32'h00000A30); 19: r = CW'(32'h00000518);
            20: r = CW'(32'h0000028C); 21: r = CW'(32'h00000146);
            22: r = CW'(32'h000000A3); 23: r = CW'(32'h00000051);
            24: r = CW'(32'h00000029); 25: r = CW'(32'h00000014);
            26: r = CW'(32'h0000000A); 27: r = CW'(32'h00000005);
            28: r = CW'(32'h00000003); default: r = CW'(32'h00000001);
        endcase
        return r;
    endfunction

    // Clamp to [-1, +1].
    function automatic q_t sat_one(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] one;
        one = PW'(ONE_Q);
        if (v > one) return ONE_Q;
        if (v < -one) return -ONE_Q;
        return q_t'(v);
    endfunction

    // Rounded Q product.
    function automatic logic signed [PW-1:0] mulq(input q_t a, input q_t b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b) + (PW'(1) <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    // Rounded Q product with the wider 1 - c term.
    function automatic logic signed [PW-1:0] mulq_t(input q_t a, input tq_t b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b) + (PW'(1) <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

endpackage

// ----- src/aarm_front.sv -----
// Front end: accepts requests, clamps axis components and queues them.
`timescale 1ns / 1ps
module aarm_front
    import aarm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [AXIS_WIDTH-1:0]  in_ax,
    input  logic [AXIS_WIDTH-1:0]  in_ay,
    input  logic [AXIS_WIDTH-1:0]  in_az,
    input  logic [ANGLE_WIDTH-1:0] in_angle,
    output logic                   q_valid,
    input  logic                   q_ready,
    output req_t                   q_data
);
    req_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              push, pop;
    req_t              cls;

    function automatic q_t clamp_axis(input logic [AXIS_WIDTH-1:0] raw);
        return sat_one(PW'($signed(raw)));
    endfunction

    always_comb begin
        cls.ax    = clamp_axis(in_ax);
        cls.ay    = clamp_axis(in_ay);
        cls.az    = clamp_axis(in_az);
        cls.angle = in_angle;
    end

    assign in_ready = (cnt_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= cls;
    end
endmodule

// ----- src/aarm_back.sv -----
// Back end: pipelined CORDIC and Rodrigues matrix assembly with a pipeline-wide hold.
`timescale 1ns / 1ps
module aarm_back
    import aarm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  req_t q_data,
    output logic out_valid,
    input  logic out_ready,
    output mat_t out_data
);
    // CORDIC stage registers
    logic signed [CW-1:0]  x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0]  y_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0]  z_reg [CORDIC_STEPS+1];
    logic [1:0]            qd_reg [CORDIC_STEPS+1];
    q_t                    ax_reg [CORDIC_STEPS+1];
    q_t                    ay_reg [CORDIC_STEPS+1];
    q_t                    az_reg [CORDIC_STEPS+1];
    logic [PIPE_STAGES-1:0] vld_reg;

    logic [31:0] theta;
    logic        take;
    logic        adv;
    assign theta = 32'(q_data.angle) << (32 - ANGLE_WIDTH);

    // advance every stage unless the result register holds an unaccepted matrix
    assign adv     = !vld_reg[PIPE_STAGES-1] || out_ready;
    assign q_ready = adv;
    assign take    = q_valid && adv;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0]  <= CORDIC_X0;
            y_reg[0]  <= '0;
            z_reg[0]  <= CW'({2'b00, theta[29:0]});
            qd_reg[0] <= theta[31:30];
            ax_reg[0] <= q_data.ax;
            ay_reg[0] <= q_data.ay;
            az_reg[0] <= q_data.az;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (!z_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_turn(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_turn(i);
                end
                qd_reg[i+1] <= qd_reg[i];
                ax_reg[i+1] <= ax_reg[i];
                ay_reg[i+1] <= ay_reg[i];
                az_reg[i+1] <= az_reg[i];
            end
        end
    end

    // stage A: round to Q, quadrant map
    q_t cx, sy, c_a, s_a, axa, aya, aza;
    assign cx = q_t'((x_reg[CORDIC_STEPS] + (CW'(1) <<< (CS_SHIFT-1))) >>> CS_SHIFT);
    assign sy = q_t'((y_reg[CORDIC_STEPS] + (CW'(1) <<< (CS_SHIFT-1))) >>> CS_SHIFT);
    always_ff @(posedge aclk) begin
        if (adv) begin
            case (qd_reg[CORDIC_STEPS])
                2'd0: begin c_a <= cx;  s_a <= sy;  end
                2'd1: begin c_a <= -sy; s_a <= cx;  end
                2'd2: begin c_a <= -cx; s_a <= -sy; end
                default: begin c_a <= sy; s_a <= -cx; end
            endcase
            axa <= ax_reg[CORDIC_STEPS];
            aya <= ay_reg[CORDIC_STEPS];
            aza <= az_reg[CORDIC_STEPS];
        end
    end

    // stage B: axis products, sine products, t
    logic signed [PW-1:0] xx, yy, zz, xy, xz, yz, xs, ys, zs;
    q_t  c_b;
    tq_t t_b;
    always_ff @(posedge aclk) begin
        if (adv) begin
            xx <= mulq(axa, axa); yy <= mulq(aya, aya); zz <= mulq(aza, aza);
            xy <= mulq(axa, aya); xz <= mulq(axa, aza); yz <= mulq(aya, aza);
            xs <= mulq(axa, s_a); ys <= mulq(aya, s_a); zs <= mulq(aza, s_a);
            c_b <= c_a;
            t_b <= tq_t'(ONE_Q) - tq_t'(c_a);
        end
    end

    // stage C: times t (axis products stay within the Q width)
    logic signed [PW-1:0] xxt, yyt, zzt, xyt, xzt, yzt, xs_c, ys_c, zs_c, c_c;
    always_ff @(posedge aclk) begin
        if (adv) begin
            xxt <= mulq_t(q_t'(xx), t_b); yyt <= mulq_t(q_t'(yy), t_b);
            zzt <= mulq_t(q_t'(zz), t_b); xyt <= mulq_t(q_t'(xy), t_b);
            xzt <= mulq_t(q_t'(xz), t_b); yzt <= mulq_t(q_t'(yz), t_b);
            xs_c <= xs; ys_c <= ys; zs_c <= zs; c_c <= PW'(c_b);
        end
    end

    // stage D: sums and clamp into the result register
    mat_t res;
    always_ff @(posedge aclk) begin
        if (adv) begin
            res.m00 <= sat_one(c_c + xxt);
            res.m01 <= sat_one(xyt - zs_c);
            res.m02 <= sat_one(xzt + ys_c);
            res.m10 <= sat_one(xyt + zs_c);
            res.m11 <= sat_one(c_c + yyt);
            res.m12 <= sat_one(yzt - xs_c);
            res.m20 <= sat_one(xzt - ys_c);
            res.m21 <= sat_one(yzt + xs_c);
            res.m22 <= sat_one(c_c + zzt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)  vld_reg <= '0;
        else if (adv)  vld_reg <= {vld_reg[PIPE_STAGES-2:0], take};
    end

    assign out_valid = vld_reg[PIPE_STAGES-1];
    assign out_data  = res;
endmodule

// ----- src/axis_angle_rotation_matrix_unit.sv -----
// Top level: axis-angle to 3x3 Rodrigues rotation matrix, stream in and out.
// One request per cycle sustained while the result side is ready. Each request
// passes from accept to result through the register that loads the CORDIC from the
// input queue, a 30-stage CORDIC (one stage per micro-rotation) and four matrix
// stages ending in the result register. While a result waits, the whole back
// pipeline holds; the 4-entry input queue keeps taking requests until it fills,
// so nothing is lost and the input side never sees the result side directly.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_unit
    import aarm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // axis_x [17:0], axis_y [35:18], axis_z [53:36], angle [69:54], zero pad
    input  logic [71:0]   s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // m00 [17:0], m01, m02, m10, m11, m12, m20, m21, m22 [161:144], zero pad
    output logic [167:0]  m_tdata
);
    logic q_valid, q_ready;
    req_t q_data;
    mat_t r;

    // Accept and clamp the axis, queue the request.
    aarm_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_ax(s_tdata[17:0]), .in_ay(s_tdata[35:18]), .in_az(s_tdata[53:36]),
        .in_angle(s_tdata[69:54]),
        .q_valid, .q_ready, .q_data
    );

    // Compute sine, cosine and the matrix.
    aarm_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_data,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(r)
    );

    assign m_tdata = {6'd0, r.m22, r.m21, r.m20, r.m12, r.m11, r.m10, r.m02, r.m01, r.m00};
endmodule
